@@ design/qat_pkg.sv @@
// Shared types, constants and reset values for the quoted argument tokenizer.
package qat_pkg;

   localparam int ARGS_LIMIT_DEFAULT = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [4:0] ARG_CAP_RESET = 5'd16;

   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_EQUALS  = 8'h3d;
   localparam logic [7:0] CHAR_CR      = 8'h0d;
   localparam logic [7:0] CHAR_LF      = 8'h0a;
   localparam logic [7:0] CHAR_DQUOTE  = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE  = 8'h27;
   localparam logic [7:0] CHAR_QUERY   = 8'h3f;
   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] QUOTE_MARKER = 8'h01;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_UNQUOTED = 2'd1;
   localparam logic [1:0] STATUS_TOO_MANY = 2'd2;

   // One classified input byte, as handed from the front end to the scanner.
   typedef struct packed {
      logic [7:0] line_byte;
      logic       line_last;
      logic       is_zero;
      logic       is_sep;
      logic       is_dquote;
      logic       is_squote;
      logic       is_query;
   } class_type;

   // One result beat.
   typedef struct packed {
      logic       starts_token;
      logic       is_content;
      logic [7:0] content_byte;
      logic [4:0] token_index;
      logic       line_done;
      logic [4:0] arg_count;
      logic [1:0] status;
   } result_type;

endpackage

@@ design/qat_fifo.sv @@
// Small register queue used between the front end, the scanner and the result port.
module qat_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ design/qat_front.sv @@
// Front end: classifies each incoming byte before it is queued for the scanner.
module qat_front (
   input  logic                 [7:0] line_byte,
   input  logic                       line_last,
   output qat_pkg::class_type         item
);

   always_comb begin
      item.line_byte = line_byte;
      item.line_last = line_last;
      item.is_zero   = (line_byte == qat_pkg::CHAR_NUL);
      item.is_sep    = (line_byte == qat_pkg::CHAR_SPACE)  ||
                       (line_byte == qat_pkg::CHAR_TAB)    ||
                       (line_byte == qat_pkg::CHAR_EQUALS) ||
                       (line_byte == qat_pkg::CHAR_CR)     ||
                       (line_byte == qat_pkg::CHAR_LF);
      item.is_dquote = (line_byte == qat_pkg::CHAR_DQUOTE);
      item.is_squote = (line_byte == qat_pkg::CHAR_SQUOTE);
      item.is_query  = (line_byte == qat_pkg::CHAR_QUERY);
   end

endmodule

@@ design/qat_back.sv @@
// Back end: the token scanner, one classified byte per cycle into the result queue while that queue has room.
module qat_back #(
   parameter int ARGS_LIMIT = qat_pkg::ARGS_LIMIT_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                  [4:0] arg_cap,
   input  logic                        in_valid,
   input  qat_pkg::class_type          in_item,
   output logic                        in_pop,
   input  logic                        out_full,
   output logic                        out_push,
   output qat_pkg::result_type         out_item
);

   localparam int CNT_W = $clog2(ARGS_LIMIT + 1);
   localparam int CMP_W = CNT_W + 6;

   typedef enum logic [1:0] {
      MODE_BETWEEN  = 2'd0,
      MODE_UNQUOTED = 2'd1,
      MODE_QUOTED   = 2'd2
   } mode_type;

   mode_type         mode_ff, mode_in;
   logic             quote_kind_ff, quote_kind_in;
   logic [CNT_W-1:0] raw_count_ff, raw_count_in;
   logic             split_done_ff, split_done_in;
   logic             first_query_ff, first_query_in;
   logic [1:0]       first_len_ff, first_len_in;
   logic             line_ended_ff, line_ended_in;

   logic [CMP_W-1:0] limit_now;
   logic [CMP_W-1:0] raw_wide;
   logic [CMP_W-1:0] idx_wide;
   logic [CMP_W-1:0] total_wide;
   logic             quote_match;
   qat_pkg::result_type res;

   assign in_pop   = in_valid & ~out_full;
   assign out_push = in_pop;
   assign out_item = res;

   assign limit_now = (CMP_W'(arg_cap) < CMP_W'(ARGS_LIMIT)) ? CMP_W'(arg_cap)
                                                              : CMP_W'(ARGS_LIMIT);
   assign raw_wide    = CMP_W'(raw_count_ff);
   assign quote_match = quote_kind_ff ? in_item.is_squote : in_item.is_dquote;

   always_comb begin
      mode_in        = mode_ff;
      quote_kind_in  = quote_kind_ff;
      raw_count_in   = raw_count_ff;
      split_done_in  = split_done_ff;
      first_query_in = first_query_ff;
      first_len_in   = first_len_ff;
      line_ended_in  = line_ended_ff;
      res            = '0;
      idx_wide       = '0;
      total_wide     = '0;

      if (!line_ended_ff) begin
         if (in_item.is_zero) begin
            line_ended_in = 1'b1;
         end else begin
            case (mode_ff)
               MODE_BETWEEN: begin
                  if (!in_item.is_sep && raw_wide < limit_now) begin
                     raw_count_in     = raw_count_ff + CNT_W'(1);
                     res.starts_token = 1'b1;
                     res.is_content   = 1'b1;
                     if (in_item.is_dquote || in_item.is_squote) begin
                        quote_kind_in    = in_item.is_squote;
                        mode_in          = MODE_QUOTED;
                        res.content_byte = qat_pkg::QUOTE_MARKER;
                     end else begin
                        mode_in          = MODE_UNQUOTED;
                        res.content_byte = in_item.line_byte;
                        if (raw_count_ff == '0) begin
                           first_query_in = in_item.is_query;
                           first_len_in   = 2'd1;
                        end
                     end
                     idx_wide        = raw_wide + CMP_W'(split_done_ff);
                     res.token_index = idx_wide[4:0];
                  end
               end
               MODE_UNQUOTED: begin
                  if (in_item.is_sep) begin
                     mode_in = MODE_BETWEEN;
                  end else begin
                     res.is_content   = 1'b1;
                     res.content_byte = in_item.line_byte;
                     // The second byte of a leading '?' token opens the split-off token.
                     if (raw_count_ff == CNT_W'(1) && first_len_ff == 2'd1) begin
                        first_len_in = 2'd2;
                        if (first_query_ff) begin
                           split_done_in    = 1'b1;
                           res.starts_token = 1'b1;
                        end
                     end
                     idx_wide        = raw_wide - CMP_W'(1) + CMP_W'(split_done_in);
                     res.token_index = idx_wide[4:0];
                  end
               end
               MODE_QUOTED: begin
                  if (quote_match) begin
                     mode_in = MODE_BETWEEN;
                  end else begin
                     res.is_content   = 1'b1;
                     res.content_byte = in_item.line_byte;
                     idx_wide         = raw_wide - CMP_W'(1) + CMP_W'(split_done_ff);
                     res.token_index  = idx_wide[4:0];
                  end
               end
               default: begin
                  mode_in = MODE_BETWEEN;
               end
            endcase
         end
      end

      if (in_item.line_last) begin
         total_wide    = CMP_W'(raw_count_in) + CMP_W'(split_done_in);
         res.line_done = 1'b1;
         if (mode_in == MODE_QUOTED) begin
            res.status = qat_pkg::STATUS_UNQUOTED;
         end else if (total_wide > limit_now) begin
            res.status = qat_pkg::STATUS_TOO_MANY;
         end else begin
            res.arg_count = total_wide[4:0];
         end
         mode_in        = MODE_BETWEEN;
         quote_kind_in  = 1'b0;
         raw_count_in   = '0;
         split_done_in  = 1'b0;
         first_query_in = 1'b0;
         first_len_in   = 2'd0;
         line_ended_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_BETWEEN;
         quote_kind_ff  <= 1'b0;
         raw_count_ff   <= '0;
         split_done_ff  <= 1'b0;
         first_query_ff <= 1'b0;
         first_len_ff   <= 2'd0;
         line_ended_ff  <= 1'b0;
      end else if (in_pop) begin
         mode_ff        <= mode_in;
         quote_kind_ff  <= quote_kind_in;
         raw_count_ff   <= raw_count_in;
         split_done_ff  <= split_done_in;
         first_query_ff <= first_query_in;
         first_len_ff   <= first_len_in;
         line_ended_ff  <= line_ended_in;
      end
   end

   a_line_end_clears: assert property (@(posedge clock) disable iff (reset)
      (out_push && res.line_done) |=>
         (mode_ff == MODE_BETWEEN && raw_count_ff == '0 && !split_done_ff && !line_ended_ff))
      else $error("line state not cleared after the final beat of a line");

   a_start_is_content: assert property (@(posedge clock) disable iff (reset)
      (out_push && res.starts_token) |-> res.is_content)
      else $error("token start reported on a byte that is not content");

   a_summary_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (out_push && !res.line_done) |->
         (res.status == qat_pkg::STATUS_OK && res.arg_count == '0))
      else $error("count or status reported before the end of the line");

   a_split_needs_query: assert property (@(posedge clock) disable iff (reset)
      split_done_ff |-> (first_query_ff && raw_count_ff != '0))
      else $error("query split recorded without a leading query token");

   a_open_token_counted: assert property (@(posedge clock) disable iff (reset)
      (mode_ff != MODE_BETWEEN) |-> (raw_count_ff != '0))
      else $error("scanner inside a token with no token counted");

endmodule

@@ design/quoted_argument_tokenizer.sv @@
// Top level of the quoted argument tokenizer: input queue, scanner, result queue.
//
// Takes one command-line byte per beat and gives exactly one result beat per byte,
// in order. A pushed byte is classified and queued, the scanner consumes it from
// the input queue and writes its result into the result queue, whose head drives
// the rsp_ ports until it is popped. Throughput is one byte per cycle while
// neither side stalls; either side may stall without losing a beat, since each
// queue holds QUEUE_DEPTH entries, two by default. The argument cap register
// resets to 16, is written through the csr_ channel (ready is always high) and
// must only be changed while no line is in flight.
module quoted_argument_tokenizer #(
   parameter int ARGS_LIMIT  = qat_pkg::ARGS_LIMIT_DEFAULT,
   parameter int QUEUE_DEPTH = qat_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_line_byte,
   input  logic       req_line_last,
   output logic       empty,
   input  logic       pop,
   output logic       rsp_starts_token,
   output logic       rsp_is_content,
   output logic [7:0] rsp_content_byte,
   output logic [4:0] rsp_token_index,
   output logic       rsp_line_done,
   output logic [4:0] rsp_arg_count,
   output logic [1:0] rsp_status,
   input  logic       valid,
   output logic       ready,
   input  logic [4:0] csr_arg_cap
);

   localparam int CLASS_W  = $bits(qat_pkg::class_type);
   localparam int RESULT_W = $bits(qat_pkg::result_type);

   logic [4:0]          arg_cap_ff, arg_cap_in;
   qat_pkg::class_type  front_item;
   qat_pkg::class_type  back_item;
   logic                class_empty;
   logic                back_pop;
   logic                result_full;
   logic                result_push;
   qat_pkg::result_type result_item;
   qat_pkg::result_type head_item;

   assign ready      = 1'b1;
   assign arg_cap_in = (valid && ready) ? csr_arg_cap : arg_cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         arg_cap_ff <= qat_pkg::ARG_CAP_RESET;
      end else begin
         arg_cap_ff <= arg_cap_in;
      end
   end

   qat_front u_front (
      .line_byte (req_line_byte),
      .line_last (req_line_last),
      .item      (front_item)
   );

   qat_fifo #(
      .WIDTH (CLASS_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_class_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_item),
      .full      (full),
      .pop       (back_pop),
      .pop_data  (back_item),
      .empty     (class_empty)
   );

   qat_back #(
      .ARGS_LIMIT (ARGS_LIMIT)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .arg_cap  (arg_cap_ff),
      .in_valid (~class_empty),
      .in_item  (back_item),
      .in_pop   (back_pop),
      .out_full (result_full),
      .out_push (result_push),
      .out_item (result_item)
   );

   qat_fifo #(
      .WIDTH (RESULT_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (result_push),
      .push_data (result_item),
      .full      (result_full),
      .pop       (pop),
      .pop_data  (head_item),
      .empty     (empty)
   );

   assign rsp_starts_token = head_item.starts_token;
   assign rsp_is_content   = head_item.is_content;
   assign rsp_content_byte = head_item.content_byte;
   assign rsp_token_index  = head_item.token_index;
   assign rsp_line_done    = head_item.line_done;
   assign rsp_arg_count    = head_item.arg_count;
   assign rsp_status       = head_item.status;

endmodule

@@ sim/quoted_argument_tokenizer_tb.sv @@
// Self-checking testbench for the quoted argument tokenizer, with its own per-byte predictor.
module quoted_argument_tokenizer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ARGS_CAP = qat_pkg::ARGS_LIMIT_DEFAULT;

   typedef enum logic [1:0] {SCAN_GAP, SCAN_BARE, SCAN_QUOTED} scan_state_type;

   logic       clock;
   logic       reset;
   logic       push;
   logic       full;
   logic [7:0] req_line_byte;
   logic       req_line_last;
   logic       empty;
   logic       pop;
   logic       rsp_starts_token;
   logic       rsp_is_content;
   logic [7:0] rsp_content_byte;
   logic [4:0] rsp_token_index;
   logic       rsp_line_done;
   logic [4:0] rsp_arg_count;
   logic [1:0] rsp_status;
   logic       valid;
   logic       ready;
   logic [4:0] csr_arg_cap;

   // Predictor state: a private copy of the register and of the line parse.
   logic [4:0]     cfg_arg_cap = qat_pkg::ARG_CAP_RESET;
   scan_state_type scan = SCAN_GAP;
   logic [7:0]     closing_quote = qat_pkg::CHAR_DQUOTE;
   int             tokens_seen = 0;
   int             split_taken = 0;
   logic           first_query = 1'b0;
   int             first_length = 0;
   logic           line_frozen = 1'b0;

   qat_pkg::result_type pending_results[$];
   int                  bytes_sent = 0;
   int                  failures = 0;
   int                  send_idle_pct = 0;
   int                  recv_idle_pct = 0;
   int                  hold_left = 0;

   quoted_argument_tokenizer u_top (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_line_byte    (req_line_byte),
      .req_line_last    (req_line_last),
      .empty            (empty),
      .pop              (pop),
      .rsp_starts_token (rsp_starts_token),
      .rsp_is_content   (rsp_is_content),
      .rsp_content_byte (rsp_content_byte),
      .rsp_token_index  (rsp_token_index),
      .rsp_line_done    (rsp_line_done),
      .rsp_arg_count    (rsp_arg_count),
      .rsp_status       (rsp_status),
      .valid            (valid),
      .ready            (ready),
      .csr_arg_cap      (csr_arg_cap)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic logic is_separator(logic [7:0] b);
      return b == qat_pkg::CHAR_SPACE || b == qat_pkg::CHAR_TAB ||
             b == qat_pkg::CHAR_EQUALS || b == qat_pkg::CHAR_CR || b == qat_pkg::CHAR_LF;
   endfunction

   function automatic int arg_limit();
      return (int'(cfg_arg_cap) < ARGS_CAP) ? int'(cfg_arg_cap) : ARGS_CAP;
   endfunction

   // Advances the line parse by one byte and returns the result it should give.
   function automatic qat_pkg::result_type tokenize_byte(logic [7:0] b, logic last);
      qat_pkg::result_type r;
      int                  total;
      r = '0;
      if (!line_frozen) begin
         if (b == qat_pkg::CHAR_NUL) begin
            line_frozen = 1'b1;
         end else if (scan == SCAN_GAP) begin
            if (!is_separator(b) && tokens_seen < arg_limit()) begin
               tokens_seen++;
               r.starts_token = 1'b1;
               r.is_content = 1'b1;
               if (b == qat_pkg::CHAR_DQUOTE || b == qat_pkg::CHAR_SQUOTE) begin
                  closing_quote = b;
                  scan = SCAN_QUOTED;
                  r.content_byte = qat_pkg::QUOTE_MARKER;
               end else begin
                  scan = SCAN_BARE;
                  r.content_byte = b;
                  if (tokens_seen == 1) begin
                     first_query = (b == qat_pkg::CHAR_QUERY);
                     first_length = 1;
                  end
               end
               r.token_index = 5'(tokens_seen - 1 + split_taken);
            end
         end else if (scan == SCAN_BARE) begin
            if (is_separator(b)) begin
               scan = SCAN_GAP;
            end else begin
               r.is_content = 1'b1;
               r.content_byte = b;
               // The second byte of a leading '?' word splits it in two.
               if (tokens_seen == 1 && first_length == 1) begin
                  first_length = 2;
                  if (first_query) begin
                     split_taken = 1;
                     r.starts_token = 1'b1;
                  end
               end
               r.token_index = 5'(tokens_seen - 1 + split_taken);
            end
         end else if (b == closing_quote) begin
            scan = SCAN_GAP;
         end else begin
            r.is_content = 1'b1;
            r.content_byte = b;
            r.token_index = 5'(tokens_seen - 1 + split_taken);
         end
      end
      if (last) begin
         total = tokens_seen + split_taken;
         r.line_done = 1'b1;
         if (scan == SCAN_QUOTED) begin
            r.status = qat_pkg::STATUS_UNQUOTED;
         end else if (total > arg_limit()) begin
            r.status = qat_pkg::STATUS_TOO_MANY;
         end else begin
            r.status = qat_pkg::STATUS_OK;
            r.arg_count = 5'(total);
         end
         scan = SCAN_GAP;
         closing_quote = qat_pkg::CHAR_DQUOTE;
         tokens_seen = 0;
         split_taken = 0;
         first_query = 1'b0;
         first_length = 0;
         line_frozen = 1'b0;
      end
      return r;
   endfunction

   function automatic string describe(qat_pkg::result_type r);
      return $sformatf("start=%0b content=%0b byte=%02h index=%0d done=%0b count=%0d status=%0d",
                       r.starts_token, r.is_content, r.content_byte, r.token_index,
                       r.line_done, r.arg_count, r.status);
   endfunction

   function automatic logic [7:0] pick_separator();
      case ($urandom_range(4))
         0: return qat_pkg::CHAR_SPACE;
         1: return qat_pkg::CHAR_TAB;
         2: return qat_pkg::CHAR_EQUALS;
         3: return qat_pkg::CHAR_CR;
         default: return qat_pkg::CHAR_LF;
      endcase
   endfunction

   function automatic logic [7:0] word_byte();
      logic [7:0] c;
      c = 8'($urandom_range(1, 255));
      while (is_separator(c) || c == qat_pkg::CHAR_DQUOTE || c == qat_pkg::CHAR_SQUOTE)
         c = 8'($urandom_range(1, 255));
      return c;
   endfunction

   task automatic note_failure(string what, qat_pkg::result_type want,
                               qat_pkg::result_type got);
      failures++;
      if (failures <= 10)
         $display("%0t: %s\n   expected %s\n   actual   %s", $realtime, what,
                  describe(want), describe(got));
   endtask

   // Offers one byte from the falling edge until a rising edge accepts it.
   task automatic send_byte(logic [7:0] b, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         push = 1'b0;
         @(negedge clock);
      end
      push = 1'b1;
      req_line_byte = b;
      req_line_last = last;
      forever begin
         @(posedge clock);
         if (!full) break;
      end
      pending_results.push_back(tokenize_byte(b, last));
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_line(string text);
      push = 1'b0;
      for (int i = 0; i < text.len(); i++)
         send_byte(text[i], i == text.len() - 1);
      push = 1'b0;
   endtask

   task automatic wait_for_drain();
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_arg_cap(logic [4:0] value);
      wait_for_drain();
      repeat (3) @(negedge clock);
      valid = 1'b1;
      csr_arg_cap = value;
      forever begin
         @(posedge clock);
         if (ready) break;
      end
      cfg_arg_cap = value;
      @(negedge clock);
      valid = 1'b0;
   endtask

   // Mostly well-formed lines with random words, quotes and separators; some pure noise.
   task automatic send_random_line();
      logic [7:0] line_bytes[$];
      logic [7:0] quote_char;
      logic [7:0] c;
      int         n_tokens;
      int         style;
      if ($urandom_range(99) < 12) begin
         repeat ($urandom_range(1, 12)) line_bytes.push_back(8'($urandom_range(255)));
      end else begin
         n_tokens = $urandom_range(0, arg_limit() + 2);
         if (n_tokens > 5 && $urandom_range(3) != 0)
            n_tokens = $urandom_range(0, 5);
         repeat ($urandom_range(0, 1)) line_bytes.push_back(pick_separator());
         for (int t = 0; t < n_tokens; t++) begin
            if (t > 0)
               repeat ($urandom_range(1, 2)) line_bytes.push_back(pick_separator());
            style = $urandom_range(9);
            if (style < 2) begin
               quote_char = $urandom_range(1) ? qat_pkg::CHAR_SQUOTE : qat_pkg::CHAR_DQUOTE;
               line_bytes.push_back(quote_char);
               repeat ($urandom_range(0, 4)) begin
                  c = 8'($urandom_range(1, 255));
                  line_bytes.push_back(c == quote_char ? qat_pkg::CHAR_SPACE : c);
               end
               // Now and then the last quoted word is left open.
               if (t != n_tokens - 1 || $urandom_range(5) != 0)
                  line_bytes.push_back(quote_char);
            end else if (style == 2) begin
               line_bytes.push_back(qat_pkg::CHAR_QUERY);
               repeat ($urandom_range(0, 4)) line_bytes.push_back(word_byte());
            end else begin
               repeat ($urandom_range(1, 5)) line_bytes.push_back(word_byte());
            end
         end
         if ($urandom_range(2) == 0)
            line_bytes.push_back(pick_separator());
         if ($urandom_range(19) == 0)
            line_bytes.insert($urandom_range(line_bytes.size()), qat_pkg::CHAR_NUL);
         if (line_bytes.size() == 0)
            line_bytes.push_back(pick_separator());
      end
      foreach (line_bytes[i])
         send_byte(line_bytes[i], i == line_bytes.size() - 1);
   endtask

   task automatic test_query_split();
      send_line("?ab x");
      send_line("? y");
   endtask

   task automatic test_quoted_tokens();
      // A single-quoted word holding a double quote and a space, then an open double quote.
      send_byte(qat_pkg::CHAR_SQUOTE, 1'b0);
      send_byte(qat_pkg::CHAR_DQUOTE, 1'b0);
      send_byte(qat_pkg::CHAR_SPACE, 1'b0);
      send_byte(qat_pkg::CHAR_SQUOTE, 1'b0);
      send_byte(qat_pkg::CHAR_DQUOTE, 1'b0);
      send_byte(8'hff, 1'b1);
      push = 1'b0;
   endtask

   task automatic test_zero_byte();
      send_byte("a", 1'b0);
      send_byte(qat_pkg::CHAR_NUL, 1'b0);
      send_byte("b", 1'b1);
      push = 1'b0;
   endtask

   task automatic test_arg_limit();
      write_arg_cap(5'd2);
      send_line("?ab\tc");
      send_line("a b=c\r");
      write_arg_cap(5'd0);
      send_line("z");
   endtask

   task automatic test_random_lines(int n_items, int send_pct, int recv_pct);
      int first;
      first = bytes_sent;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      while (bytes_sent - first < n_items)
         send_random_line();
      push = 1'b0;
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      @(posedge clock);
      hold_left = 300;
      @(negedge clock);
      test_random_lines(100, 0, 0);
   endtask

   always @(negedge clock) begin
      if (hold_left > 0) begin
         pop = 1'b0;
         hold_left--;
      end else begin
         pop = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : check_results
      qat_pkg::result_type got;
      qat_pkg::result_type want;
      if (!reset && pop && !empty) begin
         got = {rsp_starts_token, rsp_is_content, rsp_content_byte, rsp_token_index,
                rsp_line_done, rsp_arg_count, rsp_status};
         if (pending_results.size() == 0) begin
            note_failure("result beat with nothing expected", '0, got);
         end else begin
            want = pending_results.pop_front();
            if (got.starts_token !== want.starts_token || got.is_content !== want.is_content ||
                got.content_byte !== want.content_byte ||
                got.token_index !== want.token_index || got.line_done !== want.line_done ||
                got.arg_count !== want.arg_count || got.status !== want.status)
               note_failure("result beat mismatch", want, got);
         end
      end
   end

   initial begin
      reset = 1'b1;
      push = 1'b0;
      req_line_byte = '0;
      req_line_last = 1'b0;
      pop = 1'b0;
      valid = 1'b0;
      csr_arg_cap = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_query_split();
      test_quoted_tokens();
      test_zero_byte();
      test_arg_limit();

      write_arg_cap(5'd16);
      test_random_lines(350, 13, 67);
      write_arg_cap(5'd1);
      test_random_lines(120, 67, 13);
      write_arg_cap(5'd31);
      test_random_lines(150, 67, 13);
      write_arg_cap(5'($urandom_range(3, 15)));
      test_random_lines(200, 0, 0);
      test_backpressure();
      write_arg_cap(5'd16);
      test_random_lines(150, 0, 0);

      wait_for_drain();
      repeat (10) @(posedge clock);
      if (failures == 0 && pending_results.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
